// File: hw/rtl/tgp_pkg.sv
// Shared constants, codes and controller/datapath interface types for the turtle grid plotter.
package tgp_pkg;

    localparam int GRID_SIZE = 20;
    localparam int POS_W     = $clog2(GRID_SIZE);

    localparam int OP_W      = 4;
    localparam int DIST_W    = 8;
    localparam int STEP_W    = 16;
    localparam int POS_OUT_W = 5;
    localparam int ROW_OUT_W = 20;

    localparam logic [1:0] HEAD_UP    = 2'd0;
    localparam logic [1:0] HEAD_RIGHT = 2'd1;
    localparam logic [1:0] HEAD_DOWN  = 2'd2;
    localparam logic [1:0] HEAD_LEFT  = 2'd3;

    typedef enum logic [OP_W-1:0] {
        OP_PEN_UP   = 4'd1,
        OP_PEN_DOWN = 4'd2,
        OP_RIGHT    = 4'd3,
        OP_LEFT     = 4'd4,
        OP_MOVE     = 4'd5,
        OP_PRINT    = 4'd6,
        OP_STOP     = 4'd9
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MOVE,
        ST_PRINT,
        ST_STATUS
    } state_t;

    typedef struct packed {
        logic accept;
        logic set_pen;
        logic pen_val;
        logic rot_cw;
        logic rot_ccw;
        logic move_load;
        logic unk;
        logic move_step;
        logic print_row;
        logic emit_status;
    } cmd_t;

    typedef struct packed {
        logic move_done;
        logic print_done;
    } stat_t;

endpackage

// File: hw/rtl/turtle_grid_plotter_core.sv
// Turtle graphics grid plotter top level: sequencer plus datapath.
// A request is taken when start is high and busy is low; busy then stays high
// until the command is finished. Pen, turn, stop and unknown commands go straight
// to their status result; a move holds busy while the turtle walks one cell per
// cycle, marking the cells on its path when the pen is down; print holds it while
// reading one grid row per cycle from the top row down.
// Each result is driven for exactly one cycle with strobe high, starting in the
// cycle after the work that makes it; the receiver cannot stall, so it must
// take every strobed result. A status result (last high) closes each command.
module turtle_grid_plotter_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [tgp_pkg::OP_W-1:0]          op,
    input  logic [tgp_pkg::DIST_W-1:0]        distance,
    output logic                              busy,
    output logic                              strobe,
    output logic                              kind,
    output logic [tgp_pkg::STEP_W-1:0]        step_count,
    output logic [tgp_pkg::POS_OUT_W-1:0]     row_pos,
    output logic [tgp_pkg::POS_OUT_W-1:0]     col_pos,
    output logic [1:0]                        heading,
    output logic                              pen_is_down,
    output logic                              clipped,
    output logic                              unknown_op,
    output logic [tgp_pkg::POS_OUT_W-1:0]     grid_row_index,
    output logic [tgp_pkg::ROW_OUT_W-1:0]     grid_row_bits,
    output logic                              last
);

    tgp_pkg::cmd_t  cmd;
    tgp_pkg::stat_t stat;

    tgp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    tgp_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .distance       (distance),
        .cmd            (cmd),
        .stat           (stat),
        .strobe         (strobe),
        .kind           (kind),
        .step_count     (step_count),
        .row_pos        (row_pos),
        .col_pos        (col_pos),
        .heading        (heading),
        .pen_is_down    (pen_is_down),
        .clipped        (clipped),
        .unknown_op     (unknown_op),
        .grid_row_index (grid_row_index),
        .grid_row_bits  (grid_row_bits),
        .last           (last)
    );

endmodule

// File: hw/rtl/tgp_ctrl.sv
// Command sequencer: decodes requests and steps the datapath through move, print and status.
module tgp_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [tgp_pkg::OP_W-1:0]  op,
    input  tgp_pkg::stat_t            stat,
    output tgp_pkg::cmd_t             cmd,
    output logic                      busy
);

    tgp_pkg::state_t state_reg;
    tgp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= tgp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = (state_reg != tgp_pkg::ST_IDLE);
        unique case (state_reg)
            tgp_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = tgp_pkg::ST_STATUS;
                    unique case (op)
                        tgp_pkg::OP_PEN_UP:
                        begin
                            cmd.set_pen = 1'b1;
                            cmd.pen_val = 1'b0;
                        end
                        tgp_pkg::OP_PEN_DOWN:
                        begin
                            cmd.set_pen = 1'b1;
                            cmd.pen_val = 1'b1;
                        end
                        tgp_pkg::OP_RIGHT:
                        begin
                            cmd.rot_cw = 1'b1;
                        end
                        tgp_pkg::OP_LEFT:
                        begin
                            cmd.rot_ccw = 1'b1;
                        end
                        tgp_pkg::OP_MOVE:
                        begin
                            cmd.move_load = 1'b1;
                            state_next    = tgp_pkg::ST_MOVE;
                        end
                        tgp_pkg::OP_PRINT:
                        begin
                            state_next = tgp_pkg::ST_PRINT;
                        end
                        tgp_pkg::OP_STOP:
                        begin
                        end
                        default:
                        begin
                            cmd.unk = 1'b1;
                        end
                    endcase
                end
            end
            tgp_pkg::ST_MOVE:
            begin
                cmd.move_step = 1'b1;
                if (stat.move_done)
                begin
                    state_next = tgp_pkg::ST_STATUS;
                end
            end
            tgp_pkg::ST_PRINT:
            begin
                cmd.print_row = 1'b1;
                if (stat.print_done)
                begin
                    state_next = tgp_pkg::ST_STATUS;
                end
            end
            tgp_pkg::ST_STATUS:
            begin
                cmd.emit_status = 1'b1;
                state_next      = tgp_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tgp_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/tgp_datapath.sv
// Turtle state, grid bitmap, move/print counters and registered result ports.
module tgp_datapath (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic [tgp_pkg::DIST_W-1:0]        distance,
    input  tgp_pkg::cmd_t                     cmd,
    output tgp_pkg::stat_t                    stat,
    output logic                              strobe,
    output logic                              kind,
    output logic [tgp_pkg::STEP_W-1:0]        step_count,
    output logic [tgp_pkg::POS_OUT_W-1:0]     row_pos,
    output logic [tgp_pkg::POS_OUT_W-1:0]     col_pos,
    output logic [1:0]                        heading,
    output logic                              pen_is_down,
    output logic                              clipped,
    output logic                              unknown_op,
    output logic [tgp_pkg::POS_OUT_W-1:0]     grid_row_index,
    output logic [tgp_pkg::ROW_OUT_W-1:0]     grid_row_bits,
    output logic                              last
);

    localparam int POS_W = tgp_pkg::POS_W;
    localparam logic [POS_W-1:0] TOP = POS_W'(tgp_pkg::GRID_SIZE - 1);

    logic [tgp_pkg::GRID_SIZE-1:0] grid_reg [tgp_pkg::GRID_SIZE];

    logic [POS_W-1:0]          row_reg,     row_next;
    logic [POS_W-1:0]          col_reg,     col_next;
    logic [1:0]                heading_reg, heading_next;
    logic                      pen_reg,     pen_next;
    logic [tgp_pkg::STEP_W-1:0] step_reg,   step_next;
    logic [POS_W-1:0]          cnt_reg,     cnt_next;
    logic [POS_W-1:0]          idx_reg,     idx_next;
    logic                      clip_reg,    clip_next;
    logic                      unk_reg,     unk_next;
    logic                      strobe_reg,  strobe_next;

    logic                           kind_reg;
    logic [tgp_pkg::STEP_W-1:0]     step_out_reg;
    logic [tgp_pkg::POS_OUT_W-1:0]  row_out_reg;
    logic [tgp_pkg::POS_OUT_W-1:0]  col_out_reg;
    logic [1:0]                     head_out_reg;
    logic                           pen_out_reg;
    logic                           clip_out_reg;
    logic                           unk_out_reg;
    logic [tgp_pkg::POS_OUT_W-1:0]  index_out_reg;
    logic [tgp_pkg::ROW_OUT_W-1:0]  bits_out_reg;
    logic                           last_out_reg;

    logic [POS_W-1:0] room;
    logic             move_clip;

    always_comb
    begin
        case (heading_reg)
            tgp_pkg::HEAD_UP:    room = TOP - row_reg;
            tgp_pkg::HEAD_RIGHT: room = TOP - col_reg;
            tgp_pkg::HEAD_DOWN:  room = row_reg;
            default:             room = col_reg;
        endcase
    end

    assign move_clip = (distance > tgp_pkg::DIST_W'(room));

    assign stat.move_done  = (cnt_reg == '0);
    assign stat.print_done = (idx_reg == '0);

    always_comb
    begin
        row_next     = row_reg;
        col_next     = col_reg;
        heading_next = heading_reg;
        pen_next     = pen_reg;
        step_next    = step_reg;
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        clip_next    = clip_reg;
        unk_next     = unk_reg;
        strobe_next  = cmd.print_row | cmd.emit_status;

        if (cmd.accept)
        begin
            step_next = step_reg + 1'b1;
            idx_next  = TOP;
            clip_next = 1'b0;
            unk_next  = cmd.unk;
        end
        if (cmd.set_pen)
        begin
            pen_next = cmd.pen_val;
        end
        if (cmd.rot_cw)
        begin
            heading_next = heading_reg + 2'd1;
        end
        if (cmd.rot_ccw)
        begin
            heading_next = heading_reg + 2'd3;
        end
        if (cmd.move_load)
        begin
            clip_next = move_clip;
            cnt_next  = move_clip ? room : POS_W'(distance);
        end
        if (cmd.move_step && !stat.move_done)
        begin
            cnt_next = cnt_reg - 1'b1;
            case (heading_reg)
                tgp_pkg::HEAD_UP:    row_next = row_reg + 1'b1;
                tgp_pkg::HEAD_RIGHT: col_next = col_reg + 1'b1;
                tgp_pkg::HEAD_DOWN:  row_next = row_reg - 1'b1;
                default:             col_next = col_reg - 1'b1;
            endcase
        end
        if (cmd.print_row)
        begin
            idx_next = idx_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            col_reg     <= '0;
            heading_reg <= tgp_pkg::HEAD_UP;
            pen_reg     <= 1'b0;
            step_reg    <= '0;
            cnt_reg     <= '0;
            idx_reg     <= '0;
            clip_reg    <= 1'b0;
            unk_reg     <= 1'b0;
            strobe_reg  <= 1'b0;
            for (int r = 0; r < tgp_pkg::GRID_SIZE; r++)
            begin
                grid_reg[r] <= '0;
            end
        end
        else
        begin
            row_reg     <= row_next;
            col_reg     <= col_next;
            heading_reg <= heading_next;
            pen_reg     <= pen_next;
            step_reg    <= step_next;
            cnt_reg     <= cnt_next;
            idx_reg     <= idx_next;
            clip_reg    <= clip_next;
            unk_reg     <= unk_next;
            strobe_reg  <= strobe_next;
            // pen down: mark the cell under the turtle, then walk on
            if (cmd.move_step && pen_reg)
            begin
                grid_reg[row_reg][col_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.print_row)
        begin
            kind_reg      <= 1'b1;
            step_out_reg  <= '0;
            row_out_reg   <= '0;
            col_out_reg   <= '0;
            head_out_reg  <= '0;
            pen_out_reg   <= 1'b0;
            clip_out_reg  <= 1'b0;
            unk_out_reg   <= 1'b0;
            index_out_reg <= tgp_pkg::POS_OUT_W'(idx_reg);
            bits_out_reg  <= tgp_pkg::ROW_OUT_W'(grid_reg[idx_reg]);
            last_out_reg  <= 1'b0;
        end
        else if (cmd.emit_status)
        begin
            kind_reg      <= 1'b0;
            step_out_reg  <= step_reg;
            row_out_reg   <= tgp_pkg::POS_OUT_W'(row_reg);
            col_out_reg   <= tgp_pkg::POS_OUT_W'(col_reg);
            head_out_reg  <= heading_reg;
            pen_out_reg   <= pen_reg;
            clip_out_reg  <= clip_reg;
            unk_out_reg   <= unk_reg;
            index_out_reg <= '0;
            bits_out_reg  <= '0;
            last_out_reg  <= 1'b1;
        end
    end

    assign strobe         = strobe_reg;
    assign kind           = kind_reg;
    assign step_count     = step_out_reg;
    assign row_pos        = row_out_reg;
    assign col_pos        = col_out_reg;
    assign heading        = head_out_reg;
    assign pen_is_down    = pen_out_reg;
    assign clipped        = clip_out_reg;
    assign unknown_op     = unk_out_reg;
    assign grid_row_index = index_out_reg;
    assign grid_row_bits  = bits_out_reg;
    assign last           = last_out_reg;

endmodule

// File: tb/tgp_tb_pkg.sv
// Result type and scoreboard class for the turtle grid plotter testbench.
`timescale 1ns / 100ps

package tgp_tb_pkg;

    typedef struct packed {
        logic                          kind;
        logic [tgp_pkg::STEP_W-1:0]    step_count;
        logic [tgp_pkg::POS_OUT_W-1:0] row_pos;
        logic [tgp_pkg::POS_OUT_W-1:0] col_pos;
        logic [1:0]                    heading;
        logic                          pen_is_down;
        logic                          clipped;
        logic                          unknown_op;
        logic [tgp_pkg::POS_OUT_W-1:0] grid_row_index;
        logic [tgp_pkg::ROW_OUT_W-1:0] grid_row_bits;
        logic                          last;
    } plot_result_t;

    class plotter_scoreboard;

        logic [tgp_pkg::ROW_OUT_W-1:0] cells [tgp_pkg::GRID_SIZE];
        logic [tgp_pkg::POS_OUT_W-1:0] turtle_row;
        logic [tgp_pkg::POS_OUT_W-1:0] turtle_col;
        logic [1:0]                    facing;
        logic                          ink_on;
        logic [tgp_pkg::STEP_W-1:0]    steps;
        plot_result_t                  pending_results [$];

        int mismatches;
        int results_checked;
        int rows_checked;
        int clipped_moves;
        int marking_moves;

        function new();
            foreach (cells[r])
                cells[r] = '0;
            turtle_row      = '0;
            turtle_col      = '0;
            facing          = tgp_pkg::HEAD_UP;
            ink_on          = 1'b0;
            steps           = '0;
            mismatches      = 0;
            results_checked = 0;
            rows_checked    = 0;
            clipped_moves   = 0;
            marking_moves   = 0;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        // Apply one accepted request and queue the results it must produce.
        function void note_request(input logic [tgp_pkg::OP_W-1:0] code,
                                   input logic [tgp_pkg::DIST_W-1:0] stride);
            plot_result_t item;
            int           room;
            int           span;
            int           k;
            logic         clip;
            logic         unk;
            clip = 1'b0;
            unk  = 1'b0;
            case (code)
                tgp_pkg::OP_PEN_UP:   ink_on = 1'b0;
                tgp_pkg::OP_PEN_DOWN: ink_on = 1'b1;
                tgp_pkg::OP_RIGHT:    facing = facing + 2'd1;
                tgp_pkg::OP_LEFT:     facing = facing + 2'd3;
                tgp_pkg::OP_MOVE:
                begin
                    case (facing)
                        tgp_pkg::HEAD_UP:
                            room = tgp_pkg::GRID_SIZE - 1 - int'(turtle_row);
                        tgp_pkg::HEAD_RIGHT:
                            room = tgp_pkg::GRID_SIZE - 1 - int'(turtle_col);
                        tgp_pkg::HEAD_DOWN:
                            room = int'(turtle_row);
                        default:
                            room = int'(turtle_col);
                    endcase
                    clip = (int'(stride) > room);
                    span = clip ? room : int'(stride);
                    if (clip)
                        clipped_moves++;
                    if (ink_on)
                    begin
                        marking_moves++;
                        for (k = 0; k <= span; k++)
                        begin
                            case (facing)
                                tgp_pkg::HEAD_UP:
                                    cells[int'(turtle_row) + k][turtle_col] = 1'b1;
                                tgp_pkg::HEAD_RIGHT:
                                    cells[turtle_row][int'(turtle_col) + k] = 1'b1;
                                tgp_pkg::HEAD_DOWN:
                                    cells[int'(turtle_row) - k][turtle_col] = 1'b1;
                                default:
                                    cells[turtle_row][int'(turtle_col) - k] = 1'b1;
                            endcase
                        end
                    end
                    case (facing)
                        tgp_pkg::HEAD_UP:
                            turtle_row = turtle_row + tgp_pkg::POS_OUT_W'(span);
                        tgp_pkg::HEAD_RIGHT:
                            turtle_col = turtle_col + tgp_pkg::POS_OUT_W'(span);
                        tgp_pkg::HEAD_DOWN:
                            turtle_row = turtle_row - tgp_pkg::POS_OUT_W'(span);
                        default:
                            turtle_col = turtle_col - tgp_pkg::POS_OUT_W'(span);
                    endcase
                end
                tgp_pkg::OP_PRINT:
                begin
                    for (k = tgp_pkg::GRID_SIZE - 1; k >= 0; k--)
                    begin
                        item                = '0;
                        item.kind           = 1'b1;
                        item.grid_row_index = tgp_pkg::POS_OUT_W'(k);
                        item.grid_row_bits  = cells[k];
                        pending_results.push_back(item);
                    end
                end
                tgp_pkg::OP_STOP: ;
                default: unk = 1'b1;
            endcase
            steps            = steps + 1'b1;
            item             = '0;
            item.step_count  = steps;
            item.row_pos     = turtle_row;
            item.col_pos     = turtle_col;
            item.heading     = facing;
            item.pen_is_down = ink_on;
            item.clipped     = clip;
            item.unknown_op  = unk;
            item.last        = 1'b1;
            pending_results.push_back(item);
        endfunction

        function void report(input string msg);
            mismatches++;
            $display("MISMATCH: %s", msg);
        endfunction

        function void compare_field(input string name, input int unsigned got,
                                    input int unsigned want);
            if (got != want)
                report($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                 results_checked, name, got, want));
        endfunction

        function void check_result(input plot_result_t got);
            plot_result_t want;
            results_checked++;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing pending", results_checked));
                return;
            end
            want = pending_results.pop_front();
            if (want.kind)
                rows_checked++;
            compare_field("kind", 32'(got.kind), 32'(want.kind));
            compare_field("step_count", 32'(got.step_count), 32'(want.step_count));
            compare_field("row_pos", 32'(got.row_pos), 32'(want.row_pos));
            compare_field("col_pos", 32'(got.col_pos), 32'(want.col_pos));
            compare_field("heading", 32'(got.heading), 32'(want.heading));
            compare_field("pen_is_down", 32'(got.pen_is_down), 32'(want.pen_is_down));
            compare_field("clipped", 32'(got.clipped), 32'(want.clipped));
            compare_field("unknown_op", 32'(got.unknown_op), 32'(want.unknown_op));
            compare_field("grid_row_index", 32'(got.grid_row_index),
                          32'(want.grid_row_index));
            compare_field("grid_row_bits", 32'(got.grid_row_bits),
                          32'(want.grid_row_bits));
            compare_field("last", 32'(got.last), 32'(want.last));
        endfunction

    endclass

endpackage

// File: tb/tb_top.sv
// Top-level testbench for turtle_grid_plotter_core: stimulus, result monitor, verdict.
`timescale 1ns / 100ps

module tb_top;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic [tgp_pkg::OP_W-1:0]      op;
    logic [tgp_pkg::DIST_W-1:0]    distance;
    logic                          busy;
    logic                          strobe;
    logic                          kind;
    logic [tgp_pkg::STEP_W-1:0]    step_count;
    logic [tgp_pkg::POS_OUT_W-1:0] row_pos;
    logic [tgp_pkg::POS_OUT_W-1:0] col_pos;
    logic [1:0]                    heading;
    logic                          pen_is_down;
    logic                          clipped;
    logic                          unknown_op;
    logic [tgp_pkg::POS_OUT_W-1:0] grid_row_index;
    logic [tgp_pkg::ROW_OUT_W-1:0] grid_row_bits;
    logic                          last;

    tgp_tb_pkg::plotter_scoreboard sb;
    int                            requests_sent;

    turtle_grid_plotter_core u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .op             (op),
        .distance       (distance),
        .busy           (busy),
        .strobe         (strobe),
        .kind           (kind),
        .step_count     (step_count),
        .row_pos        (row_pos),
        .col_pos        (col_pos),
        .heading        (heading),
        .pen_is_down    (pen_is_down),
        .clipped        (clipped),
        .unknown_op     (unknown_op),
        .grid_row_index (grid_row_index),
        .grid_row_bits  (grid_row_bits),
        .last           (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("watchdog expired with %0d results still pending", sb.pending());
        $display("[FAIL] regression broken");
        $finish;
    end

    always @(posedge clk)
    begin : result_monitor
        tgp_tb_pkg::plot_result_t seen;
        if (rst_n && strobe)
        begin
            seen.kind           = kind;
            seen.step_count     = step_count;
            seen.row_pos        = row_pos;
            seen.col_pos        = col_pos;
            seen.heading        = heading;
            seen.pen_is_down    = pen_is_down;
            seen.clipped        = clipped;
            seen.unknown_op     = unknown_op;
            seen.grid_row_index = grid_row_index;
            seen.grid_row_bits  = grid_row_bits;
            seen.last           = last;
            sb.check_result(seen);
        end
    end

    // Start stays high across back-to-back requests; this task drops it only when a gap is drawn.
    task automatic send_request(input logic [tgp_pkg::OP_W-1:0] code,
                                input logic [tgp_pkg::DIST_W-1:0] stride,
                                input int max_gap);
        int gap;
        gap = int'($urandom_range(0, max_gap));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        op       <= code;
        distance <= stride;
        do
            @(posedge clk);
        while (busy);
        sb.note_request(code, stride);
        requests_sent++;
    endtask

    task automatic send_random_request(input int max_gap);
        int                         pick;
        logic [tgp_pkg::OP_W-1:0]   code;
        logic [tgp_pkg::DIST_W-1:0] stride;
        pick   = int'($urandom_range(0, 99));
        stride = tgp_pkg::DIST_W'($urandom_range(0, 255));
        if (pick < 8)
            code = tgp_pkg::OP_PEN_UP;
        else if (pick < 20)
            code = tgp_pkg::OP_PEN_DOWN;
        else if (pick < 30)
            code = tgp_pkg::OP_RIGHT;
        else if (pick < 38)
            code = tgp_pkg::OP_LEFT;
        else if (pick < 80)
        begin
            code = tgp_pkg::OP_MOVE;
            if ($urandom_range(0, 4) != 0)
                stride = tgp_pkg::DIST_W'($urandom_range(0, 24));
        end
        else if (pick < 87)
            code = tgp_pkg::OP_PRINT;
        else if (pick < 90)
            code = tgp_pkg::OP_STOP;
        else
        begin
            do
                code = tgp_pkg::OP_W'($urandom_range(0, 15));
            while (code inside {tgp_pkg::OP_PEN_UP, tgp_pkg::OP_PEN_DOWN, tgp_pkg::OP_RIGHT,
                                tgp_pkg::OP_LEFT, tgp_pkg::OP_MOVE, tgp_pkg::OP_PRINT,
                                tgp_pkg::OP_STOP});
        end
        send_request(code, stride, max_gap);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int i;
        int max_gap;
        sb            = new();
        requests_sent = 0;
        rst_n         <= 1'b0;
        start         <= 1'b0;
        op            <= '0;
        distance      <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: corners, exact fit, clipping, wraps, unknown codes, print
        send_request(tgp_pkg::OP_STOP,     8'd0,   4);
        send_request(4'd0,                 8'd255, 4);
        send_request(4'd15,                8'd0,   4);
        send_request(tgp_pkg::OP_PEN_DOWN, 8'd0,   0);
        send_request(tgp_pkg::OP_MOVE,     8'd0,   0);
        send_request(tgp_pkg::OP_MOVE,     8'd255, 3);
        send_request(tgp_pkg::OP_RIGHT,    8'd0,   0);
        send_request(tgp_pkg::OP_MOVE,     8'd19,  2);
        send_request(tgp_pkg::OP_RIGHT,    8'd0,   0);
        send_request(tgp_pkg::OP_MOVE,     8'd20,  5);
        send_request(tgp_pkg::OP_RIGHT,    8'd0,   0);
        send_request(tgp_pkg::OP_MOVE,     8'd5,   0);
        send_request(tgp_pkg::OP_PEN_UP,   8'd170, 1);
        send_request(tgp_pkg::OP_MOVE,     8'd255, 0);
        send_request(tgp_pkg::OP_LEFT,     8'd0,   0);
        send_request(tgp_pkg::OP_LEFT,     8'd0,   2);
        send_request(tgp_pkg::OP_LEFT,     8'd0,   0);
        send_request(tgp_pkg::OP_LEFT,     8'd0,   0);
        send_request(tgp_pkg::OP_PRINT,    8'd0,   3);
        send_request(tgp_pkg::OP_STOP,     8'd85,  0);
        send_request(4'd7,                 8'd0,   0);
        wait_drained();

        for (i = 0; i < 330; i++)
        begin
            if (i % 110 == 55)
                wait_drained();
            max_gap = ((i / 40) % 3 == 1) ? 0 : 16;
            send_random_request(max_gap);
        end

        start <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        $display("Sent %0d requests; checked %0d results, %0d of them grid rows.",
                 requests_sent, sb.results_checked, sb.rows_checked);
        $display("Moves with pen down: %0d; moves cut at the grid edge: %0d; mismatches: %0d.",
                 sb.marking_moves, sb.clipped_moves, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
